// ===== rtl/core/sts_pkg.sv =====
// shared types and codes for the script token scanner
package sts_pkg;

    // token kind codes
    localparam logic [2:0] K_WORD     = 3'd0;
    localparam logic [2:0] K_DELIM    = 3'd1;
    localparam logic [2:0] K_STRING   = 3'd2;
    localparam logic [2:0] K_NUMBER   = 3'd3;
    localparam logic [2:0] K_FINISHED = 3'd4;

    // relation operator codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_EQ   = 3'd1;
    localparam logic [2:0] OP_NE   = 3'd2;
    localparam logic [2:0] OP_NOT  = 3'd3;
    localparam logic [2:0] OP_LE   = 3'd4;
    localparam logic [2:0] OP_LT   = 3'd5;
    localparam logic [2:0] OP_GE   = 3'd6;
    localparam logic [2:0] OP_GT   = 3'd7;

    // result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // one result item
    typedef struct packed {
        logic [7:0] tok_byte;
        logic       byte_valid;
        logic [2:0] token_kind;
        logic [2:0] rel_op;
        logic       last_of_token;
        logic       last_of_step;
    } res_t;

    // results produced by one accepted item, first one in r0
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } wr_t;

endpackage

// ===== rtl/core/sts_scan.sv =====
// scanner state and the per-item next-state and result logic
module sts_scan
    import sts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] ch,
    input  logic       end_of_text,
    output wr_t        wr
);

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_LINE_CR, M_BLOCK,
        M_BLOCK_STAR, M_REL, M_PAIR, M_STRING, M_RUN
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] hb;
        logic       hv;
        logic [2:0] hk;
        logic [2:0] ho;
        logic       emit;
        logic [2:0] ekind;
    } take_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic [2:0] held_kind_reg, held_kind_next;
    logic [2:0] held_op_reg, held_op_next;

    take_t      tk;
    logic       eot;
    logic       pre_v, sec_v;
    res_t       pre_r, sec_r;
    logic [2:0] dop;

    function automatic res_t mk(input logic [7:0] b, input logic v, input logic [2:0] k,
                                input logic [2:0] op, input logic last);
        res_t r;
        r.tok_byte      = b;
        r.byte_valid    = v;
        r.token_kind    = k;
        r.rel_op        = op;
        r.last_of_token = last;
        r.last_of_step  = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] single_op(input logic [7:0] c);
        logic [2:0] op;
        case (c)
            "!":     op = OP_NOT;
            "<":     op = OP_LT;
            ">":     op = OP_GT;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic [2:0] double_op(input logic [7:0] c);
        logic [2:0] op;
        case (c)
            "=":     op = OP_EQ;
            "!":     op = OP_NE;
            "<":     op = OP_LE;
            default: op = OP_GE;
        endcase
        return op;
    endfunction

    // bytes that end a number or word run
    function automatic logic ends_run(input logic [7:0] c);
        return (c inside {8'h00, 8'h09, 8'h0d, " ", "!", ":", ";", ",", "+", "-", "<",
                          ">", "'", "/", "*", "%", "^", "=", "(", ")", "&", "|",
                          "\"", "{", "}"});
    endfunction

    // start of a new token from the idle state
    function automatic take_t idle_take(input logic [7:0] c);
        take_t t;
        t.mode  = M_IDLE;
        t.hb    = 8'h00;
        t.hv    = 1'b0;
        t.hk    = K_WORD;
        t.ho    = OP_NONE;
        t.emit  = 1'b0;
        t.ekind = K_WORD;
        if (c <= 8'h20) begin
            t.mode = M_IDLE;
        end else if (c == "/") begin
            t.mode = M_SLASH;
        end else if (c inside {"=", "!", "<", ">"}) begin
            t.mode = M_REL;
            t.hb   = c;
            t.hv   = 1'b1;
            t.hk   = K_DELIM;
            t.ho   = single_op(c);
        end else if (c inside {"&", "|"}) begin
            t.mode = M_PAIR;
            t.hb   = c;
            t.hv   = 1'b1;
            t.hk   = K_WORD;
        end else if (c inside {"+", "-", "*", "^", "%", ";", "(", ")", ",", "'", ":",
                               "{", "}", "."}) begin
            t.emit  = 1'b1;
            t.ekind = K_DELIM;
        end else if (c == "\"") begin
            t.mode = M_STRING;
        end else if (c inside {["0":"9"]}) begin
            t.mode = M_RUN;
            t.hb   = c;
            t.hv   = 1'b1;
            t.hk   = K_NUMBER;
        end else if (c inside {["a":"z"], ["A":"Z"], [8'h80:8'hff], "#", "_", "@", "$",
                               "?"}) begin
            t.mode = M_RUN;
            t.hb   = c;
            t.hv   = 1'b1;
            t.hk   = K_WORD;
        end else begin
            t.emit  = 1'b1;
            t.ekind = K_WORD;
        end
        return t;
    endfunction

    assign eot = end_of_text | (ch == 8'h00);
    assign tk  = idle_take(ch);
    assign dop = double_op(held_byte_reg);

    // next state and up to two results
    always_comb begin
        mode_next       = mode_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_kind_next  = held_kind_reg;
        held_op_next    = held_op_reg;
        pre_v           = 1'b0;
        pre_r           = '0;
        sec_v           = 1'b0;
        sec_r           = '0;
        if (eot) begin
            // flush any pending token, then the finished marker
            pre_v = 1'b1;
            case (mode_reg)
                M_SLASH:  pre_r = mk("/", 1'b1, K_DELIM, OP_NONE, 1'b1);
                M_REL:    pre_r = mk(held_byte_reg, 1'b1, K_DELIM, held_op_reg, 1'b1);
                M_PAIR:   pre_r = mk(held_byte_reg, 1'b1, K_WORD, OP_NONE, 1'b1);
                M_STRING: begin
                    if (held_valid_reg) begin
                        pre_r = mk(held_byte_reg, 1'b1, K_STRING, OP_NONE, 1'b1);
                    end else begin
                        pre_r = mk(8'h00, 1'b0, K_STRING, OP_NONE, 1'b1);
                    end
                end
                M_RUN:    pre_r = mk(held_byte_reg, 1'b1, held_kind_reg, OP_NONE, 1'b1);
                default:  pre_v = 1'b0;
            endcase
            sec_v           = 1'b1;
            sec_r           = mk(8'h00, 1'b0, K_FINISHED, OP_NONE, 1'b1);
            mode_next       = M_IDLE;
            held_byte_next  = 8'h00;
            held_valid_next = 1'b0;
            held_kind_next  = K_WORD;
            held_op_next    = OP_NONE;
        end else begin
            // default: hand the byte to a fresh token start
            mode_next       = tk.mode;
            held_byte_next  = tk.hb;
            held_valid_next = tk.hv;
            held_kind_next  = tk.hk;
            held_op_next    = tk.ho;
            sec_v           = tk.emit;
            sec_r           = mk(ch, 1'b1, tk.ekind, OP_NONE, 1'b1);
            case (mode_reg)
                M_SLASH: begin
                    if (ch == "/" || ch == "*") begin
                        mode_next = (ch == "/") ? M_LINE : M_BLOCK;
                        sec_v     = 1'b0;
                    end else begin
                        pre_v = 1'b1;
                        pre_r = mk("/", 1'b1, K_DELIM, OP_NONE, 1'b1);
                    end
                end
                M_LINE: begin
                    mode_next       = (ch == 8'h0d) ? M_LINE_CR : M_LINE;
                    held_byte_next  = held_byte_reg;
                    held_valid_next = held_valid_reg;
                    held_kind_next  = held_kind_reg;
                    held_op_next    = held_op_reg;
                    sec_v           = 1'b0;
                end
                M_LINE_CR: begin
                    // byte after the line end is dropped
                    mode_next       = M_IDLE;
                    held_byte_next  = 8'h00;
                    held_valid_next = 1'b0;
                    held_kind_next  = K_WORD;
                    held_op_next    = OP_NONE;
                    sec_v           = 1'b0;
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    held_byte_next  = held_byte_reg;
                    held_valid_next = held_valid_reg;
                    held_kind_next  = held_kind_reg;
                    held_op_next    = held_op_reg;
                    sec_v           = 1'b0;
                    if (ch == "*") begin
                        mode_next = M_BLOCK_STAR;
                    end else if (mode_reg == M_BLOCK_STAR && ch == "/") begin
                        mode_next       = M_IDLE;
                        held_byte_next  = 8'h00;
                        held_valid_next = 1'b0;
                        held_kind_next  = K_WORD;
                        held_op_next    = OP_NONE;
                    end else begin
                        mode_next = M_BLOCK;
                    end
                end
                M_REL: begin
                    pre_v = 1'b1;
                    if (ch == "=") begin
                        pre_r           = mk(held_byte_reg, 1'b1, K_DELIM, dop, 1'b0);
                        sec_v           = 1'b1;
                        sec_r           = mk(ch, 1'b1, K_DELIM, dop, 1'b1);
                        mode_next       = M_IDLE;
                        held_byte_next  = 8'h00;
                        held_valid_next = 1'b0;
                        held_kind_next  = K_WORD;
                        held_op_next    = OP_NONE;
                    end else begin
                        pre_r = mk(held_byte_reg, 1'b1, K_DELIM, held_op_reg, 1'b1);
                    end
                end
                M_PAIR: begin
                    pre_v = 1'b1;
                    if (ch == held_byte_reg) begin
                        pre_r           = mk(held_byte_reg, 1'b1, K_DELIM, OP_NONE, 1'b0);
                        sec_v           = 1'b1;
                        sec_r           = mk(ch, 1'b1, K_DELIM, OP_NONE, 1'b1);
                        mode_next       = M_IDLE;
                        held_byte_next  = 8'h00;
                        held_valid_next = 1'b0;
                        held_kind_next  = K_WORD;
                        held_op_next    = OP_NONE;
                    end else begin
                        pre_r = mk(held_byte_reg, 1'b1, K_WORD, OP_NONE, 1'b1);
                    end
                end
                M_STRING: begin
                    sec_v = 1'b0;
                    if (ch == "\"" || ch == 8'h0d) begin
                        pre_v = 1'b1;
                        if (held_valid_reg) begin
                            pre_r = mk(held_byte_reg, 1'b1, K_STRING, OP_NONE, 1'b1);
                        end else begin
                            pre_r = mk(8'h00, 1'b0, K_STRING, OP_NONE, 1'b1);
                        end
                        mode_next       = M_IDLE;
                        held_byte_next  = 8'h00;
                        held_valid_next = 1'b0;
                        held_kind_next  = K_WORD;
                        held_op_next    = OP_NONE;
                    end else begin
                        pre_v           = held_valid_reg;
                        pre_r           = mk(held_byte_reg, 1'b1, K_STRING, OP_NONE, 1'b0);
                        mode_next       = M_STRING;
                        held_byte_next  = ch;
                        held_valid_next = 1'b1;
                        held_kind_next  = held_kind_reg;
                        held_op_next    = held_op_reg;
                    end
                end
                M_RUN: begin
                    pre_v = 1'b1;
                    if (ends_run(ch)) begin
                        pre_r = mk(held_byte_reg, 1'b1, held_kind_reg, OP_NONE, 1'b1);
                    end else begin
                        pre_r           = mk(held_byte_reg, 1'b1, held_kind_reg, OP_NONE, 1'b0);
                        sec_v           = 1'b0;
                        mode_next       = M_RUN;
                        held_byte_next  = ch;
                        held_valid_next = held_valid_reg;
                        held_kind_next  = held_kind_reg;
                        held_op_next    = held_op_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // pack results in order and mark the last one of this item
    always_comb begin
        wr.n  = {1'b0, pre_v} + {1'b0, sec_v};
        wr.r0 = pre_v ? pre_r : sec_r;
        wr.r1 = sec_r;
        wr.r0.last_of_step = ~(pre_v & sec_v);
        wr.r1.last_of_step = 1'b1;
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            held_kind_reg  <= K_WORD;
            held_op_reg    <= OP_NONE;
        end else if (accept) begin
            mode_reg       <= mode_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_kind_reg  <= held_kind_next;
            held_op_reg    <= held_op_next;
        end
    end

endmodule

// ===== rtl/core/sts_queue.sv =====
// small result queue: takes up to two results a cycle, gives one when popped
module sts_queue
    import sts_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  wr_t  wr,
    output logic room,
    output logic head_valid,
    input  logic pop,
    output res_t head
);

    res_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       n_in;
    logic             do_pop;

    assign n_in       = push ? wr.n : 2'd0;
    assign do_pop     = pop & head_valid;
    assign head_valid = (count_reg != '0);
    assign room       = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign head       = mem[rd_ptr_reg];

    // storage writes
    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            mem[wr_ptr_reg] <= wr.r0;
        end
        if (n_in == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= wr.r1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_in);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(do_pop);
            count_reg  <= count_reg + CNT_W'(n_in) - CNT_W'(do_pop);
        end
    end

endmodule

// ===== rtl/core/script_token_scanner.sv =====
// top level of the script token scanner
// Streaming lexer for C-like script text. One source byte enters per item on
// the s_ channel and every accepted byte is scanned in the cycle it is taken;
// its results (zero, one or two token bytes) appear on the m_ channel from
// the next cycle on, one result per cycle while m_tready is high, in order.
// A byte is accepted every cycle while the four-entry result queue has room
// for two results, so new bytes are taken while earlier results still wait;
// bytes that release two results (a two-character operator, or a held byte
// plus a one-byte token) fill the queue, and the queue absorbs that against
// following bytes that yield none, such as whitespace and comments. s_tlast,
// or a zero byte, ends the text: any open token is flushed, a finished
// marker follows and the scanner returns to its reset state.
module script_token_scanner
    import sts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tok_byte, [8] byte_valid, [11:9] rel_op,
                                   // [12] last_of_step, [15:13] zero
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_of_token
);

    logic accept;
    wr_t  wr;
    res_t head;

    assign accept = s_tvalid & s_tready;

    // token scanning
    sts_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .ch          (s_tdata),
        .end_of_text (s_tlast),
        .wr          (wr)
    );

    // result queue
    sts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .wr         (wr),
        .room       (s_tready),
        .head_valid (m_tvalid),
        .pop        (m_tready),
        .head       (head)
    );

    // output packing
    assign m_tdata = {3'b000, head.last_of_step, head.rel_op, head.byte_valid, head.tok_byte};
    assign m_tuser = head.token_kind;
    assign m_tlast = head.last_of_token;

endmodule

// ===== test/script_token_scanner_checker.sv =====
// checker for the script token scanner: predicts token bytes and compares results
`timescale 1ns / 100ps

module script_token_scanner_checker
    import sts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    // scanner states of the predictor
    typedef enum logic [3:0] {
        SM_IDLE,
        SM_SLASH,
        SM_LINE,
        SM_LINE_CR,
        SM_BLOCK,
        SM_BLOCK_STAR,
        SM_REL,
        SM_PAIR,
        SM_STRING,
        SM_RUN
    } scan_state_t;

    scan_state_t mode;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic [2:0]  held_kind;
    logic [2:0]  held_op;

    // results of the current item, then the ordered store of expected token bytes
    res_t step_res [2];
    int   step_n;
    res_t token_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // bytes that end a number or word
    function automatic logic run_ender(input logic [7:0] c);
        case (c)
            8'h00, 8'h09, 8'h0D,
            " ", "!", ":", ";", ",", "+", "-", "<", ">", "'", "/", "*",
            "%", "^", "=", "(", ")", "&", "|", "\"", "{", "}": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // one-byte delimiters with no lookahead
    function automatic logic single_delim(input logic [7:0] c);
        case (c)
            "+", "-", "*", "^", "%", ";", "(", ")", ",", "'", ":", "{", "}", ".":
                return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c >= 8'h80)
            return 1'b1;
        case (c)
            "#", "_", "@", "$", "?": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] lone_op(input logic [7:0] c);
        case (c)
            "!":     return OP_NOT;
            "<":     return OP_LT;
            ">":     return OP_GT;
            default: return OP_NONE;
        endcase
    endfunction

    function automatic logic [2:0] paired_op(input logic [7:0] c);
        case (c)
            "=":     return OP_EQ;
            "!":     return OP_NE;
            "<":     return OP_LE;
            default: return OP_GE;
        endcase
    endfunction

    task automatic push_result(input logic [7:0] b, input logic v, input logic [2:0] kind,
                               input logic [2:0] op, input logic last);
        res_t r;
        r.tok_byte      = b;
        r.byte_valid    = v;
        r.token_kind    = kind;
        r.rel_op        = op;
        r.last_of_token = last;
        r.last_of_step  = 1'b0;
        step_res[step_n] = r;
        step_n++;
    endtask

    task automatic clear_hold();
        mode       = SM_IDLE;
        held_byte  = 8'h00;
        held_valid = 1'b0;
        held_kind  = K_WORD;
        held_op    = OP_NONE;
    endtask

    task automatic take_byte(input scan_state_t next, input logic [7:0] c,
                             input logic [2:0] kind);
        mode       = next;
        held_byte  = c;
        held_valid = 1'b1;
        held_kind  = kind;
    endtask

    // closing quote, CR or end of text: held byte, or an empty string item
    task automatic flush_string();
        if (held_valid)
            push_result(held_byte, 1'b1, K_STRING, OP_NONE, 1'b1);
        else
            push_result(8'h00, 1'b0, K_STRING, OP_NONE, 1'b1);
    endtask

    // first byte of a new token, whitespace dropped
    task automatic start_scan(input logic [7:0] c);
        clear_hold();
        if (c > 8'h20) begin
            if (c == "/") begin
                mode = SM_SLASH;
            end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
                take_byte(SM_REL, c, K_DELIM);
                held_op = lone_op(c);
            end else if (c == "&" || c == "|") begin
                take_byte(SM_PAIR, c, K_WORD);
            end else if (single_delim(c)) begin
                push_result(c, 1'b1, K_DELIM, OP_NONE, 1'b1);
            end else if (c == "\"") begin
                mode = SM_STRING;
            end else if (c >= "0" && c <= "9") begin
                take_byte(SM_RUN, c, K_NUMBER);
            end else if (word_start(c)) begin
                take_byte(SM_RUN, c, K_WORD);
            end else begin
                push_result(c, 1'b1, K_WORD, OP_NONE, 1'b1);
            end
        end
    endtask

    // advance the scanner by one accepted item and queue what it releases
    task automatic scan_byte(input logic [7:0] c, input logic eot);
        logic [2:0] op;
        int         i;
        step_n = 0;
        if (eot || c == 8'h00) begin
            case (mode)
                SM_SLASH:  push_result("/", 1'b1, K_DELIM, OP_NONE, 1'b1);
                SM_REL:    push_result(held_byte, 1'b1, K_DELIM, held_op, 1'b1);
                SM_PAIR:   push_result(held_byte, 1'b1, K_WORD, OP_NONE, 1'b1);
                SM_STRING: flush_string();
                SM_RUN:    push_result(held_byte, 1'b1, held_kind, OP_NONE, 1'b1);
                default: begin
                end
            endcase
            push_result(8'h00, 1'b0, K_FINISHED, OP_NONE, 1'b1);
            clear_hold();
        end else begin
            case (mode)
                SM_SLASH: begin
                    if (c == "/") begin
                        mode = SM_LINE;
                    end else if (c == "*") begin
                        mode = SM_BLOCK;
                    end else begin
                        push_result("/", 1'b1, K_DELIM, OP_NONE, 1'b1);
                        start_scan(c);
                    end
                end
                SM_LINE: begin
                    if (c == 8'h0D)
                        mode = SM_LINE_CR;
                end
                // byte after the comment's CR is swallowed
                SM_LINE_CR: clear_hold();
                SM_BLOCK: begin
                    if (c == "*")
                        mode = SM_BLOCK_STAR;
                end
                SM_BLOCK_STAR: begin
                    if (c == "/")
                        clear_hold();
                    else if (c != "*")
                        mode = SM_BLOCK;
                end
                SM_REL: begin
                    if (c == "=") begin
                        op = paired_op(held_byte);
                        push_result(held_byte, 1'b1, K_DELIM, op, 1'b0);
                        push_result(c, 1'b1, K_DELIM, op, 1'b1);
                        clear_hold();
                    end else begin
                        push_result(held_byte, 1'b1, K_DELIM, held_op, 1'b1);
                        start_scan(c);
                    end
                end
                SM_PAIR: begin
                    if (c == held_byte) begin
                        push_result(held_byte, 1'b1, K_DELIM, OP_NONE, 1'b0);
                        push_result(c, 1'b1, K_DELIM, OP_NONE, 1'b1);
                        clear_hold();
                    end else begin
                        push_result(held_byte, 1'b1, K_WORD, OP_NONE, 1'b1);
                        start_scan(c);
                    end
                end
                SM_STRING: begin
                    if (c == "\"" || c == 8'h0D) begin
                        flush_string();
                        clear_hold();
                    end else begin
                        if (held_valid)
                            push_result(held_byte, 1'b1, K_STRING, OP_NONE, 1'b0);
                        held_byte  = c;
                        held_valid = 1'b1;
                    end
                end
                SM_RUN: begin
                    if (run_ender(c)) begin
                        push_result(held_byte, 1'b1, held_kind, OP_NONE, 1'b1);
                        start_scan(c);
                    end else begin
                        push_result(held_byte, 1'b1, held_kind, OP_NONE, 1'b0);
                        held_byte = c;
                    end
                end
                default: start_scan(c);
            endcase
        end
        if (step_n > 0)
            step_res[step_n - 1].last_of_step = 1'b1;
        for (i = 0; i < step_n; i++)
            token_q.push_back(step_res[i]);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // results are compared before the same edge's input is scanned
    always @(posedge aclk) begin : watch
        res_t want;
        if (!aresetn) begin
            clear_hold();
            token_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    $error("result item with nothing expected: tdata 0x%0h tuser 0x%0h",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = token_q.pop_front();
                    check_field("tok_byte", want.tok_byte, m_tdata[7:0]);
                    check_field("byte_valid", want.byte_valid, m_tdata[8]);
                    check_field("rel_op", want.rel_op, m_tdata[11:9]);
                    check_field("last_of_step", want.last_of_step, m_tdata[12]);
                    check_field("tdata padding", 0, m_tdata[15:13]);
                    check_field("token_kind", want.token_kind, m_tuser);
                    check_field("last_of_token", want.last_of_token, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata, s_tlast);
        end
        pending = token_q.size();
    end

endmodule

// ===== test/script_token_scanner_tb.sv =====
// testbench top for the script token scanner: stimulus, flow control and verdict
`timescale 1ns / 100ps

module script_token_scanner_tb;
    import sts_pkg::*;

    localparam int N_RANDOM    = 1550;
    localparam int QUIET_TAIL  = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [8*14-1:0] DELIM_CHARS = "+-*^%;(),':{}.";
    localparam logic [8*4-1:0]  REL_CHARS   = "=!<>";
    localparam logic [8*5-1:0]  WORD_MARKS  = "#_@$?";

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int cycles    = 0;
    int n_sent    = 0;
    bit gaps_on   = 1'b1;
    bit hold_req  = 1'b0;

    script_token_scanner i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    script_token_scanner_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // offer one item, with a random idle burst first
    task automatic send_byte(input logic [7:0] c, input logic eot);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = eot;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 1)
            return 8'h61 + 8'($urandom_range(0, 25));
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    // bytes that continue a word without ending it
    function automatic logic [7:0] word_body();
        int idx;
        case ($urandom_range(0, 5))
            0, 1:    return rand_letter();
            2:       return rand_digit();
            3:       return 8'($urandom_range(128, 255));
            4: begin
                idx = $urandom_range(0, 4);
                return WORD_MARKS[8*idx +: 8];
            end
            default: return ($urandom_range(0, 1) == 1) ? "." : "~";
        endcase
    endfunction

    // any byte that neither ends a string nor the text
    function automatic logic [7:0] string_body();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == "\"" || b == 8'h0D)
            b = "s";
        return b;
    endfunction

    // one random fragment of script text, mostly well formed
    task automatic send_piece();
        int         len;
        int         i;
        int         idx;
        logic [7:0] b;
        case ($urandom_range(0, 21))
            // identifier
            0, 1, 2, 3: begin
                case ($urandom_range(0, 3))
                    0:       b = rand_letter();
                    1:       b = 8'($urandom_range(128, 255));
                    2: begin
                        idx = $urandom_range(0, 4);
                        b   = WORD_MARKS[8*idx +: 8];
                    end
                    default: b = rand_letter();
                endcase
                send_byte(b, 1'b0);
                len = $urandom_range(0, 5);
                for (i = 0; i < len; i++)
                    send_byte(word_body(), 1'b0);
            end
            // number
            4, 5: begin
                send_byte(rand_digit(), 1'b0);
                len = $urandom_range(0, 4);
                for (i = 0; i < len; i++)
                    send_byte(($urandom_range(0, 3) == 0) ? rand_letter() : rand_digit(), 1'b0);
            end
            // quoted string, closed by a quote or by CR
            6, 7: begin
                send_byte("\"", 1'b0);
                len = $urandom_range(0, 5);
                for (i = 0; i < len; i++)
                    send_byte(string_body(), 1'b0);
                send_byte(($urandom_range(0, 3) == 0) ? 8'h0D : "\"", 1'b0);
            end
            // relation operator, lone or with '='
            8, 9: begin
                idx = $urandom_range(0, 3);
                send_byte(REL_CHARS[8*idx +: 8], 1'b0);
                if ($urandom_range(0, 1) == 1)
                    send_byte("=", 1'b0);
            end
            // && and ||, or a lone one
            10: begin
                b = ($urandom_range(0, 1) == 1) ? "&" : "|";
                send_byte(b, 1'b0);
                if ($urandom_range(0, 1) == 1)
                    send_byte(b, 1'b0);
            end
            11, 12: begin
                idx = $urandom_range(0, 13);
                send_byte(DELIM_CHARS[8*idx +: 8], 1'b0);
            end
            // line comment; the byte after CR is swallowed
            13: begin
                send_byte("/", 1'b0);
                send_byte("/", 1'b0);
                len = $urandom_range(0, 6);
                for (i = 0; i < len; i++)
                    send_byte(string_body(), 1'b0);
                send_byte(8'h0D, 1'b0);
                send_byte(8'($urandom_range(1, 255)), 1'b0);
            end
            // block comment with stray stars
            14: begin
                send_byte("/", 1'b0);
                send_byte("*", 1'b0);
                len = $urandom_range(0, 6);
                for (i = 0; i < len; i++)
                    send_byte(($urandom_range(0, 2) == 0) ? "*" : string_body(), 1'b0);
                send_byte("*", 1'b0);
                send_byte("/", 1'b0);
            end
            15, 16: begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++)
                    send_byte(8'($urandom_range(1, 32)), 1'b0);
            end
            17, 18: send_byte(8'($urandom_range(0, 255)), 1'b0);
            19:     send_byte("/", 1'b0);
            // end of text, by tlast or by a zero byte
            default: begin
                if ($urandom_range(0, 3) == 0)
                    send_byte(8'h00, 1'b0);
                else
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    initial begin : stimulus
        bit held_off;
        bit paused;
        held_off = 1'b0;
        paused   = 1'b0;

        // reset, released at a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: word, <=, number then &&, !, empty string, high byte, lone |
        send_byte("A", 1'b0);   send_byte("<", 1'b0);   send_byte("=", 1'b0);
        send_byte("9", 1'b0);   send_byte("&", 1'b0);   send_byte("&", 1'b0);
        send_byte("!", 1'b0);   send_byte("\"", 1'b0);  send_byte("\"", 1'b0);
        send_byte(8'hFF, 1'b0); send_byte("|", 1'b0);   send_byte(8'h20, 1'b0);
        // block comment, line comment with swallowed byte, one-byte word
        send_byte("/", 1'b0);   send_byte("*", 1'b0);   send_byte("*", 1'b0);
        send_byte("/", 1'b0);   send_byte("/", 1'b0);   send_byte("/", 1'b0);
        send_byte(8'h0D, 1'b0); send_byte("~", 1'b0);   send_byte("~", 1'b0);
        // string closed by CR, lone = and ., zero byte ends text after >
        send_byte("\"", 1'b0);  send_byte("q", 1'b0);   send_byte(8'h0D, 1'b0);
        send_byte("=", 1'b0);   send_byte(".", 1'b0);   send_byte(8'h01, 1'b0);
        send_byte(">", 1'b0);   send_byte(8'h00, 1'b0);
        // open string and open comment cut off by end of text
        send_byte("\"", 1'b0);  send_byte("z", 1'b0);   send_byte(8'h7F, 1'b1);
        send_byte("/", 1'b0);   send_byte("*", 1'b0);   send_byte(8'h00, 1'b1);
        wait_drained();

        // random script text
        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            if (!held_off && n_sent >= 400) begin
                held_off = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && n_sent >= 900) begin
                paused = 1'b1;
                wait_drained();
            end
            if (n_sent >= N_RANDOM - QUIET_TAIL)
                gaps_on = 1'b0;
            send_piece();
        end
        send_byte(8'h00, 1'b1);
        wait_drained();
        repeat (20) @(negedge aclk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== script_token_scanner.f =====
rtl/core/sts_pkg.sv
rtl/core/sts_scan.sv
rtl/core/sts_queue.sv
rtl/core/script_token_scanner.sv
test/script_token_scanner_checker.sv
test/script_token_scanner_tb.sv
